// File: rtl/sqp_pkg.sv
// sqp_pkg: item types, status codes and constants for the sorted priority queue
// no dependencies; imported by sorted_insert_priority_queue
`timescale 1ns / 1ps

package sqp_pkg;

  // request kinds
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // result status codes
  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_DEQUEUED = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // value returned by a dequeue on an empty queue
  localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

  // request item
  typedef struct packed {
    logic               req_type;
    logic signed [31:0] item_value;
    logic        [15:0] item_priority;
  } in_t;

  // result item
  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] data_out;
    logic        [3:0]  occupancy;
  } out_t;

  // one stored queue entry
  typedef struct packed {
    logic        [15:0] prio;
    logic signed [31:0] value;
  } entry_t;

endpackage

// File: rtl/sorted_insert_priority_queue.sv
// sorted_insert_priority_queue: bounded priority queue kept sorted in a memory
// depends on sqp_pkg (item types, status codes)
`timescale 1ns / 1ps

// Usage
// - req channel (req_valid / req_stall / req): one item is either an enqueue
//   (value and priority) or a dequeue. It is taken when req_valid is high and
//   req_stall is low. req_stall stays high while an item is being worked on.
// - rsp channel (rsp_valid / rsp_stall / rsp): exactly one result per item,
//   in order: status, removed value (-1 on empty, 0 on enqueue) and the
//   number of stored entries after the item (modulo 16).
// - entries live in a DEPTH-deep single-write, single-read memory with a
//   registered read port; one sequencer walks it one entry at a time.
// - an enqueue walks back from the tail, moving each entry with a larger
//   priority number back one place, then writes the new entry into the
//   hole; a dequeue reads the front entry as the result and moves the rest
//   forward one place; a rejected enqueue and a dequeue on empty do no walk.
//   Each step of the walk costs a memory read then a compare-and-write, so
//   the walk sets the rate: no new item is taken until the result goes out.
// - a new item is taken while an earlier result still waits in the output
//   register; the walk then holds in its final state until that register
//   frees, so a stalled receiver loses nothing.
// - reset clears the entry count and the handshake state; memory contents
//   are not cleared, since only entries below the count are ever read.
module sorted_insert_priority_queue #(
  parameter int DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sqp_pkg::in_t  req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sqp_pkg::out_t rsp
);
  import sqp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_ENQ_RD  = 6'b000010,
    S_ENQ_CMP = 6'b000100,
    S_ENQ_PUT = 6'b001000,
    S_DEQ_RD  = 6'b010000,
    S_DEQ_MV  = 6'b100000
  } state_t;

  // sequencer and bookkeeping registers
  state_t          state, state_next;
  logic            done, done_next;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_pend, count_pend_next;
  logic [CW-1:0]   pos, pos_next;
  in_t             req_q;
  out_t            res, res_next;

  // entry memory
  entry_t          mem [DEPTH];
  entry_t          rd_data;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;

  logic [CW-1:0]   pos_inc;
  logic [CW-1:0]   pos_dec;
  logic            rsp_free;
  logic            req_take;

  assign pos_inc  = pos + CW'(1);
  assign pos_dec  = pos - CW'(1);
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE) || done;
  assign req_take  = req_valid && !req_stall;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer: walk the sorted array one entry per step
  always_comb begin
    state_next      = state;
    done_next       = done;
    count_pend_next = count_pend;
    pos_next        = pos;
    res_next        = res;
    rd_addr         = pos[AW-1:0];
    wr_en           = 1'b0;
    wr_addr         = pos[AW-1:0];
    wr_data         = rd_data;

    unique case (state)
      S_IDLE: begin
        if (done) begin
          if (rsp_free) begin
            done_next = 1'b0;
          end
        end else if (req_valid) begin
          if (req.req_type == REQ_ENQ) begin
            if (count == CW'(DEPTH)) begin
              res_next        = '{status: ST_FULL, data_out: '0, occupancy: 4'(count)};
              count_pend_next = count;
              done_next       = 1'b1;
            end else begin
              pos_next   = count;
              state_next = (count == '0) ? S_ENQ_PUT : S_ENQ_RD;
            end
          end else begin
            if (count == '0) begin
              res_next        = '{status: ST_EMPTY, data_out: EMPTY_VALUE,
                                  occupancy: 4'(count)};
              count_pend_next = count;
              done_next       = 1'b1;
            end else begin
              pos_next   = '0;
              state_next = S_DEQ_RD;
            end
          end
        end
      end
      // read the entry just in front of the hole
      S_ENQ_RD: begin
        rd_addr    = pos_dec[AW-1:0];
        state_next = S_ENQ_CMP;
      end
      // larger priority number moves back one place
      S_ENQ_CMP: begin
        if (rd_data.prio > req_q.item_priority) begin
          wr_en      = 1'b1;
          wr_data    = rd_data;
          pos_next   = pos_dec;
          state_next = (pos == CW'(1)) ? S_ENQ_PUT : S_ENQ_RD;
        end else begin
          state_next = S_ENQ_PUT;
        end
      end
      // drop the new entry into the hole
      S_ENQ_PUT: begin
        wr_en           = 1'b1;
        wr_data         = '{prio: req_q.item_priority, value: req_q.item_value};
        count_pend_next = count + CW'(1);
        res_next        = '{status: ST_ENQUEUED, data_out: '0,
                            occupancy: 4'(count + CW'(1))};
        done_next       = 1'b1;
        state_next      = S_IDLE;
      end
      S_DEQ_RD: begin
        state_next = S_DEQ_MV;
      end
      // front entry is the result, the rest move forward one place
      S_DEQ_MV: begin
        if (pos == '0) begin
          res_next.data_out = rd_data.value;
        end else begin
          wr_en   = 1'b1;
          wr_addr = pos_dec[AW-1:0];
          wr_data = rd_data;
        end
        pos_next = pos_inc;
        if (pos_inc < count) begin
          state_next = S_DEQ_RD;
        end else begin
          count_pend_next    = count - CW'(1);
          res_next.status    = ST_DEQUEUED;
          res_next.occupancy = 4'(count - CW'(1));
          done_next          = 1'b1;
          state_next         = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (done && rsp_free) begin
        rsp_valid <= 1'b1;
        count     <= count_pend;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    count_pend <= count_pend_next;
    pos        <= pos_next;
    res        <= res_next;
    if (req_take) begin
      req_q <= req;
    end
    if (done && rsp_free) begin
      rsp <= res;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL) |-> count == CW'(DEPTH))
    else $error("full status while queue not full");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_EMPTY) |-> count == '0)
    else $error("empty status while queue holds entries");

  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.occupancy == 4'(count))
    else $error("reported occupancy differs from entry count");
`endif

endmodule
